@@ rtl/core/prt_pkg.sv @@
// shared types, codes and helpers for the pending request tracker
// no dependencies
package prt_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEV_W     = 11;
    localparam int CMD_W     = 8;
    localparam int TAG_W     = 8;
    localparam int TIME_W    = 32;
    localparam int RXID_W    = 29;
    localparam int LEN_W     = 7;
    localparam int PAY_W     = 64;
    localparam int CNT_W     = 32;
    localparam int NUM_CNT   = 8;
    localparam int CSEL_W    = 3;
    localparam int REPLY_LEN = 8;
    localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd10000;

    // statistics counter indexes
    localparam logic [CSEL_W-1:0] CNT_TX         = 3'd0;
    localparam logic [CSEL_W-1:0] CNT_RX         = 3'd1;
    localparam logic [CSEL_W-1:0] CNT_RX_GOOD    = 3'd2;
    localparam logic [CSEL_W-1:0] CNT_TX_FAILED  = 3'd3;
    localparam logic [CSEL_W-1:0] CNT_DECL_PEND  = 3'd4;
    localparam logic [CSEL_W-1:0] CNT_DECL_FULL  = 3'd5;
    localparam logic [CSEL_W-1:0] CNT_TIMEOUT    = 3'd6;
    localparam logic [CSEL_W-1:0] CNT_RX_UNKNOWN = 3'd7;

    typedef logic [SLOT_W-1:0] t_slot_idx;

    typedef enum logic [1:0] {
        OP_SEND     = 2'd0,
        OP_RX_FRAME = 2'd1,
        OP_SWEEP    = 2'd2,
        OP_READ_CNT = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        RS_SENT          = 4'd0,
        RS_DECL_PENDING  = 4'd1,
        RS_TX_FAILED     = 4'd2,
        RS_DECL_FULL     = 4'd3,
        RS_REPLY_MATCHED = 4'd4,
        RS_REPLY_UNKNOWN = 4'd5,
        RS_TIMEOUT       = 4'd6,
        RS_SWEEP_DONE    = 4'd7,
        RS_COUNTER       = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [DEV_W-1:0]    device_id;
        logic [CMD_W-1:0]    command_code;
        logic                tx_accepted;
        logic [TAG_W-1:0]    requester_tag;
        logic [TIME_W-1:0]   now_us;
        logic [RXID_W-1:0]   rx_frame_id;
        logic [LEN_W-1:0]    rx_length;
        logic [PAY_W-1:0]    rx_payload;
        logic [CSEL_W-1:0]   counter_select;
    } t_req_item;

    typedef struct packed {
        t_status             status;
        logic [3:0]          slot_index;
        logic [DEV_W-1:0]    result_device_id;
        logic [TAG_W-1:0]    result_tag;
        logic [PAY_W-1:0]    reply_payload;
        logic [CNT_W-1:0]    counter_value;
        logic                last;
    } t_rsp_item;

    typedef struct packed {
        logic [DEV_W-1:0]    device;
        logic [CMD_W-1:0]    command;
        logic [TIME_W-1:0]   stamp;
        logic [TAG_W-1:0]    requester;
    } t_slot_entry;

    // per-slot verdicts of the compare unit
    typedef struct packed {
        logic dup;
        logic rx_hit;
        logic expired;
    } t_slot_eval;

    // slot number as reported, modulo 16
    function automatic logic [3:0] slot_num(input t_slot_idx idx);
        logic [SLOT_W+3:0] w;
        w = {4'b0000, idx};
        return w[3:0];
    endfunction

    function automatic t_rsp_item make_rsp(
        input t_status          status,
        input logic [3:0]       slot,
        input logic [DEV_W-1:0] dev,
        input logic [TAG_W-1:0] tag,
        input logic [PAY_W-1:0] payload,
        input logic [CNT_W-1:0] cnt,
        input logic             last
    );
        t_rsp_item r;
        r.status           = status;
        r.slot_index       = slot;
        r.result_device_id = dev;
        r.result_tag       = tag;
        r.reply_payload    = payload;
        r.counter_value    = cnt;
        r.last             = last;
        return r;
    endfunction

endpackage

@@ rtl/core/prt_slot_store.sv @@
// slot field memory: one write port, one registered read port
// depends on prt_pkg
module prt_slot_store
    import prt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_we,
    input  t_slot_idx   i_waddr,
    input  t_slot_entry i_wdata,
    input  t_slot_idx   i_raddr,
    output t_slot_entry o_rdata
);

    t_slot_entry r_mem [SLOTS];
    t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/prt_slot_unit.sv @@
// shared compare unit: key match, reply match and age check for one slot
// depends on prt_pkg
module prt_slot_unit
    import prt_pkg::*;
(
    input  t_slot_entry       i_entry,
    input  logic              i_live,
    input  t_req_item         i_item,
    input  logic [TIME_W-1:0] i_max_age,
    output t_slot_eval        o_eval
);

    logic [TIME_W-1:0] age;
    logic [RXID_W-1:0] dev_ext;
    logic              len_ok;

    assign age     = i_item.now_us - i_entry.stamp;
    assign dev_ext = {{(RXID_W-DEV_W){1'b0}}, i_entry.device};
    assign len_ok  = (i_item.rx_length == LEN_W'(REPLY_LEN));

    always_comb begin
        o_eval.dup     = i_live && (i_entry.device == i_item.device_id)
                         && (i_entry.command == i_item.command_code);
        o_eval.rx_hit  = i_live && len_ok && (dev_ext == i_item.rx_frame_id)
                         && (i_entry.command == i_item.rx_payload[CMD_W-1:0]);
        o_eval.expired = i_live && (age > i_max_age);
    end

endmodule

@@ rtl/core/prt_stat_counters.sv @@
// eight wrapping statistics counters with per-counter increment and one read mux
// depends on prt_pkg
module prt_stat_counters
    import prt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NUM_CNT-1:0] i_inc,
    input  logic [CSEL_W-1:0]  i_sel,
    output logic [CNT_W-1:0]   o_value
);

    logic [CNT_W-1:0] r_cnt [NUM_CNT];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CNT; i++) begin
            if (!i_rst_n) begin
                r_cnt[i] <= '0;
            end else if (i_inc[i]) begin
                r_cnt[i] <= r_cnt[i] + CNT_W'(1);
            end
        end
    end

    assign o_value = r_cnt[i_sel];

endmodule

@@ rtl/core/pending_request_tracker_core.sv @@
// pending request tracker: send/reply/sweep/read over a table of SLOTS slots
// flow: send, rx frame and sweep scan the slots one per cycle through the shared compare unit
//   (a sweep hit stalls while the result register is full), then a finish state loads the result;
//   read goes straight to finish; a new item is taken only in idle, once the last result is registered
// reset: synchronous active low; clears live bits, counters and the age limit (10000 us);
//   slot fields are not cleared; depends on prt_pkg, slot store, slot unit, stat counters
module pending_request_tracker_core
    import prt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_req_item         i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_rsp_item         o_out_data,
    // age limit write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TIME_W-1:0] i_cfg_data
);

    // sequencer state
    t_state            r_state, n_state;
    t_req_item         r_item, n_item;
    t_slot_idx         r_idx, n_idx;
    logic [SLOTS-1:0]  r_live, n_live;
    logic [TIME_W-1:0] r_max_age;

    // scan results: first key/reply match and lowest free slot
    logic              r_found, n_found;
    t_slot_idx         r_found_idx, n_found_idx;
    logic [DEV_W-1:0]  r_hit_dev, n_hit_dev;
    logic [TAG_W-1:0]  r_hit_tag, n_hit_tag;
    logic              r_free_found, n_free_found;
    t_slot_idx         r_free_idx, n_free_idx;

    // output register
    logic              r_out_valid, n_out_valid;
    t_rsp_item         r_out, n_out;

    // datapath hookups
    t_slot_idx         rd_addr;
    t_slot_entry       rd_entry;
    t_slot_entry       wr_entry;
    logic              mem_we;
    t_slot_eval        eval;
    logic [NUM_CNT-1:0] inc_mask;
    logic [CNT_W-1:0]  cnt_value;
    logic              out_free;
    logic              scan_last;
    logic              scan_stall;

    assign out_free   = !r_out_valid || i_out_ready;
    assign scan_last  = (r_idx == SLOT_W'(SLOTS - 1));
    // a sweep hit has to wait until the result register can take it
    assign scan_stall = (r_item.opcode == OP_SWEEP) && eval.expired && !out_free;

    assign wr_entry.device    = r_item.device_id;
    assign wr_entry.command   = r_item.command_code;
    assign wr_entry.stamp     = r_item.now_us;
    assign wr_entry.requester = r_item.requester_tag;

    prt_slot_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_free_idx),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    prt_slot_unit u_unit (
        .i_entry   (rd_entry),
        .i_live    (r_live[r_idx]),
        .i_item    (r_item),
        .i_max_age (r_max_age),
        .o_eval    (eval)
    );

    prt_stat_counters u_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (inc_mask),
        .i_sel   (r_item.counter_select),
        .o_value (cnt_value)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.opcode == OP_READ_CNT) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!scan_stall && scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer actions
    always_comb begin
        n_item       = r_item;
        n_idx        = r_idx;
        n_live       = r_live;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_hit_dev    = r_hit_dev;
        n_hit_tag    = r_hit_tag;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        inc_mask     = '0;
        mem_we       = 1'b0;
        rd_addr      = r_idx;
        o_in_ready   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                rd_addr    = '0;
                if (i_in_valid) begin
                    n_item       = i_in_data;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            ST_SCAN: begin
                rd_addr = scan_stall ? r_idx : r_idx + SLOT_W'(1);
                if (!scan_stall) begin
                    n_idx = r_idx + SLOT_W'(1);
                    unique case (r_item.opcode)
                        OP_SEND: begin
                            if (eval.dup && !r_found) begin
                                n_found     = 1'b1;
                                n_found_idx = r_idx;
                            end
                            if (!r_live[r_idx] && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_idx;
                            end
                        end
                        OP_RX_FRAME: begin
                            if (eval.rx_hit && !r_found) begin
                                n_found     = 1'b1;
                                n_found_idx = r_idx;
                                n_hit_dev   = rd_entry.device;
                                n_hit_tag   = rd_entry.requester;
                            end
                        end
                        OP_SWEEP: begin
                            // expired slot: report now, free it
                            if (eval.expired) begin
                                n_live[r_idx]         = 1'b0;
                                inc_mask[CNT_TIMEOUT] = 1'b1;
                                n_out_valid           = 1'b1;
                                n_out = make_rsp(RS_TIMEOUT, slot_num(r_idx),
                                                 rd_entry.device, rd_entry.requester,
                                                 '0, '0, 1'b0);
                            end
                        end
                        OP_READ_CNT: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    unique case (r_item.opcode)
                        OP_SEND: begin
                            priority if (r_found) begin
                                inc_mask[CNT_DECL_PEND] = 1'b1;
                                n_out = make_rsp(RS_DECL_PENDING, slot_num(r_found_idx),
                                                 r_item.device_id, r_item.requester_tag,
                                                 '0, '0, 1'b1);
                            end else if (!r_item.tx_accepted) begin
                                inc_mask[CNT_TX_FAILED] = 1'b1;
                                n_out = make_rsp(RS_TX_FAILED, 4'd0,
                                                 r_item.device_id, r_item.requester_tag,
                                                 '0, '0, 1'b1);
                            end else if (r_free_found) begin
                                inc_mask[CNT_TX]   = 1'b1;
                                mem_we             = 1'b1;
                                n_live[r_free_idx] = 1'b1;
                                n_out = make_rsp(RS_SENT, slot_num(r_free_idx),
                                                 r_item.device_id, r_item.requester_tag,
                                                 '0, '0, 1'b1);
                            end else begin
                                // frame went out, but no slot to track it
                                inc_mask[CNT_TX]        = 1'b1;
                                inc_mask[CNT_DECL_FULL] = 1'b1;
                                n_out = make_rsp(RS_DECL_FULL, 4'd0,
                                                 r_item.device_id, r_item.requester_tag,
                                                 '0, '0, 1'b1);
                            end
                        end
                        OP_RX_FRAME: begin
                            inc_mask[CNT_RX] = 1'b1;
                            if (r_found) begin
                                inc_mask[CNT_RX_GOOD] = 1'b1;
                                n_live[r_found_idx]   = 1'b0;
                                n_out = make_rsp(RS_REPLY_MATCHED, slot_num(r_found_idx),
                                                 r_hit_dev, r_hit_tag,
                                                 r_item.rx_payload, '0, 1'b1);
                            end else begin
                                inc_mask[CNT_RX_UNKNOWN] = 1'b1;
                                n_out = make_rsp(RS_REPLY_UNKNOWN, 4'd0, '0, '0,
                                                 '0, '0, 1'b1);
                            end
                        end
                        OP_SWEEP: begin
                            n_out = make_rsp(RS_SWEEP_DONE, 4'd0, '0, '0, '0, '0, 1'b1);
                        end
                        OP_READ_CNT: begin
                            n_out = make_rsp(RS_COUNTER, 4'd0, '0, '0, '0,
                                             cnt_value, 1'b1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_max_age   <= MAX_AGE_RESET;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_max_age <= i_cfg_data;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_found_idx  <= n_found_idx;
        r_hit_dev    <= n_hit_dev;
        r_hit_tag    <= n_hit_tag;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_out        <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // only sweep timeouts come out without the last flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.status == RS_TIMEOUT)
        else $error("non-final result that is not a timeout");

    // a transfer in starts a multi-cycle job
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while previous job still running");

    // a new request never lands on a live slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !r_live[r_free_idx])
        else $error("slot write over a live entry");

    // counter reads skip the slot scan
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_item.opcode != OP_READ_CNT)
        else $error("counter read entered the slot scan");
`endif

endmodule
